// ===== rtl/core/tcc_pkg.sv =====
`default_nettype none

package tcc_pkg;

  localparam int CellW = 14;

  localparam logic [1:0] ACT_PUT         = 2'd0;
  localparam logic [1:0] ACT_SCROLL_UP   = 2'd1;
  localparam logic [1:0] ACT_SCROLL_DOWN = 2'd2;
  localparam logic [1:0] ACT_SELECT      = 2'd3;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [7:0] COLOR_RESET = 8'd7;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOAD   = 5'b00010,
    ST_EXEC   = 5'b00100,
    ST_FOLLOW = 5'b01000,
    ST_STORE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic exec;
    logic follow_step;
    logic store;
  } dp_cmd_t;

  typedef struct packed {
    logic follow_more;
    logic out_busy;
  } dp_stat_t;

  typedef struct packed {
    logic             mem_write;
    logic [CellW-1:0] mem_cell;
    logic [7:0]       mem_char;
    logic [7:0]       mem_attr;
    logic [CellW-1:0] cursor_out;
    logic [CellW-1:0] start_out;
    logic [1:0]       active_console;
  } rsp_word_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcc_cmd_if.sv =====
`default_nettype none

interface tcc_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [1:0] console_index;
  logic [7:0] char_code;

  modport source (output valid, output action, output console_index, output char_code,
                  input ready);
  modport sink (input valid, input action, input console_index, input char_code,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tcc_rsp_if.sv =====
`default_nettype none

interface tcc_rsp_if;
  logic        valid;
  logic        ready;
  logic        mem_write;
  logic [13:0] mem_cell;
  logic [7:0]  mem_char;
  logic [7:0]  mem_attr;
  logic [13:0] cursor_out;
  logic [13:0] start_out;
  logic [1:0]  active_console;

  modport source (output valid, output mem_write, output mem_cell, output mem_char,
                  output mem_attr, output cursor_out, output start_out,
                  output active_console, input ready);
  modport sink (input valid, input mem_write, input mem_cell, input mem_char,
                input mem_attr, input cursor_out, input start_out,
                input active_console, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/text_console_cursor_scroll.sv =====
// Channel  Dir  Word
// cmd      in   action, console_index, char_code
// rsp      out  mem_write, mem_cell, mem_char, mem_attr, cursor_out, start_out,
//               active_console
// cfg      in   cfg_we / cfg_wdata: char_color
//
// An item passes through accept, load, execute, follow check and store; the
// follow check moves the start toward the cursor, stopping at the region end.
// The per-console cursor, start and column registers are read once and written
// at most once per item; the follow loop steps the start one line a cycle.
// Synchronous reset puts every cursor and start at its region base.
// A new word is accepted while a finished result waits in the output register;
// the store step holds until that register is free.
`default_nettype none

module text_console_cursor_scroll #(
  parameter int NUM_CONSOLES = 4,
  parameter int LINE_CELLS   = 80,
  parameter int SCREEN_CELLS = 2000,
  parameter int VMEM_CELLS   = 16384
) (
  input  logic       clk,
  input  logic       rst,
  tcc_cmd_if.sink    cmd,
  tcc_rsp_if.source  rsp,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import tcc_pkg::*;

  dp_cmd_t   dp_cmd;
  dp_stat_t  stat;
  rsp_word_t rsp_word;
  logic      rsp_valid;

  tcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .stat      (stat),
    .dp_cmd    (dp_cmd)
  );

  tcc_datapath #(
    .NUM_CONSOLES (NUM_CONSOLES),
    .LINE_CELLS   (LINE_CELLS),
    .SCREEN_CELLS (SCREEN_CELLS),
    .VMEM_CELLS   (VMEM_CELLS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .dp_cmd        (dp_cmd),
    .stat          (stat),
    .action        (cmd.action),
    .console_index (cmd.console_index),
    .char_code     (cmd.char_code),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .rsp_ready     (rsp.ready),
    .rsp_valid     (rsp_valid),
    .rsp_word      (rsp_word)
  );

  assign rsp.valid          = rsp_valid;
  assign rsp.mem_write      = rsp_word.mem_write;
  assign rsp.mem_cell       = rsp_word.mem_cell;
  assign rsp.mem_char       = rsp_word.mem_char;
  assign rsp.mem_attr       = rsp_word.mem_attr;
  assign rsp.cursor_out     = rsp_word.cursor_out;
  assign rsp.start_out      = rsp_word.start_out;
  assign rsp.active_console = rsp_word.active_console;

endmodule

`default_nettype wire

// ===== rtl/core/tcc_ctrl.sv =====
`default_nettype none

module tcc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  tcc_pkg::dp_stat_t  stat,
  output tcc_pkg::dp_cmd_t   dp_cmd
);
  import tcc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    cmd_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd_ready      = 1'b1;
        dp_cmd.capture = cmd_valid;
        if (cmd_valid) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        dp_cmd.load = 1'b1;
        state_next  = ST_EXEC;
      end
      ST_EXEC: begin
        dp_cmd.exec = 1'b1;
        state_next  = ST_FOLLOW;
      end
      ST_FOLLOW: begin
        if (stat.follow_more) begin
          dp_cmd.follow_step = 1'b1;
        end else begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        if (!stat.out_busy) begin
          dp_cmd.store = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/tcc_datapath.sv =====
`default_nettype none

module tcc_datapath #(
  parameter int NUM_CONSOLES = 4,
  parameter int LINE_CELLS   = 80,
  parameter int SCREEN_CELLS = 2000,
  parameter int VMEM_CELLS   = 16384
) (
  input  logic                clk,
  input  logic                rst,
  input  tcc_pkg::dp_cmd_t    dp_cmd,
  output tcc_pkg::dp_stat_t   stat,
  input  logic [1:0]          action,
  input  logic [1:0]          console_index,
  input  logic [7:0]          char_code,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                rsp_ready,
  output logic                rsp_valid,
  output tcc_pkg::rsp_word_t  rsp_word
);
  import tcc_pkg::*;

  localparam int RegionCells = VMEM_CELLS / NUM_CONSOLES;
  localparam int CW = $clog2(VMEM_CELLS + SCREEN_CELLS + LINE_CELLS + 1) + 1;
  localparam int LW = $clog2(LINE_CELLS);
  localparam int IW = (NUM_CONSOLES > 1) ? $clog2(NUM_CONSOLES) : 1;

  localparam logic [CW-1:0] Region = CW'(RegionCells);
  localparam logic [CW-1:0] Line   = CW'(LINE_CELLS);
  localparam logic [CW-1:0] Screen = CW'(SCREEN_CELLS);
  localparam logic [LW-1:0] LastCol = LW'(LINE_CELLS - 1);
  localparam bit NewlineOk = (RegionCells > LINE_CELLS);

  logic [CW-1:0] cursor_cell  [NUM_CONSOLES];
  logic [CW-1:0] window_start [NUM_CONSOLES];
  logic [LW-1:0] column       [NUM_CONSOLES];
  logic [1:0]    current_console;
  logic [7:0]    char_color;

  logic [1:0]    act;
  logic [1:0]    idx;
  logic [7:0]    ch;
  logic          kvalid;
  logic [IW-1:0] sel;
  logic [CW-1:0] base;
  logic [CW-1:0] lim;
  logic [CW-1:0] cur;
  logic [CW-1:0] st;
  logic [LW-1:0] col;
  logic          wr;
  logic [CW-1:0] wr_cell;
  logic [7:0]    wc;

  logic          k_ok;
  logic [IW-1:0] sel_c;
  logic [CW-1:0] st_end;
  logic [1:0]    current_next;

  assign k_ok   = (int'(idx) < NUM_CONSOLES);
  assign sel_c  = k_ok ? IW'(idx) : IW'(current_console);
  assign st_end = st + Screen;

  assign current_next = (kvalid && act == ACT_SELECT) ? idx : current_console;

  assign stat.follow_more = kvalid && (act == ACT_PUT) && (cur >= st_end) && (st_end < lim);
  assign stat.out_busy    = rsp_valid && !rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CONSOLES; i++) begin
        cursor_cell[i]  <= CW'(i * RegionCells);
        window_start[i] <= CW'(i * RegionCells);
        column[i]       <= '0;
      end
      current_console <= '0;
      char_color      <= COLOR_RESET;
      rsp_valid       <= 1'b0;
    end else begin
      if (cfg_we) char_color <= cfg_wdata;

      if (dp_cmd.store) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      if (dp_cmd.store) begin
        if (kvalid) begin
          cursor_cell[sel]  <= cur;
          window_start[sel] <= st;
          column[sel]       <= col;
        end
        current_console <= current_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      act <= action;
      idx <= console_index;
      ch  <= char_code;
    end

    if (dp_cmd.load) begin
      kvalid  <= k_ok;
      sel     <= sel_c;
      cur     <= cursor_cell[sel_c];
      st      <= window_start[sel_c];
      col     <= column[sel_c];
      base    <= CW'(idx) * Region;
      lim     <= CW'(idx) * Region + Region;
      wr      <= 1'b0;
      wr_cell <= '0;
      wc      <= '0;
    end

    if (dp_cmd.exec && kvalid) begin
      case (act)
        ACT_PUT: begin
          if (ch == CH_NEWLINE) begin
            if (NewlineOk && (cur - base) < (Region - Line)) begin
              cur <= cur - CW'(col) + Line;
              col <= '0;
            end
          end else if (ch == CH_BACKSPACE) begin
            if (cur > base) begin
              cur     <= cur - 1'b1;
              col     <= (col == '0) ? LastCol : col - 1'b1;
              wr      <= 1'b1;
              wr_cell <= cur - 1'b1;
              wc      <= CH_SPACE;
            end
          end else begin
            if (cur + 1'b1 < lim) begin
              cur     <= cur + 1'b1;
              col     <= (col == LastCol) ? '0 : col + 1'b1;
              wr      <= 1'b1;
              wr_cell <= cur;
              wc      <= ch;
            end
          end
        end
        ACT_SCROLL_UP: begin
          if (st > base) st <= st - Line;
        end
        ACT_SCROLL_DOWN: begin
          if (st_end < lim) st <= st + Line;
        end
        ACT_SELECT: begin
        end
        default: begin
        end
      endcase
    end

    if (dp_cmd.follow_step) st <= st + Line;

    if (dp_cmd.store) begin
      rsp_word.mem_write      <= wr;
      rsp_word.mem_cell       <= wr ? CellW'(wr_cell) : '0;
      rsp_word.mem_char       <= wr ? wc : '0;
      rsp_word.mem_attr       <= wr ? char_color : '0;
      rsp_word.cursor_out     <= CellW'(cur);
      rsp_word.start_out      <= CellW'(st);
      rsp_word.active_console <= current_next;
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_text_console_cursor_scroll.sv =====
`timescale 1ns / 100ps

module tb_text_console_cursor_scroll;
  import tcc_pkg::*;

  localparam int NCON        = 4;
  localparam int LINE        = 80;
  localparam int SCREEN      = 2000;
  localparam int VMEM        = 16384;
  localparam int REGION      = VMEM / NCON;
  localparam int SETTLE      = 12;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] console;
    logic [7:0] code;
  } cmd_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  tcc_cmd_if cmd_bus ();
  tcc_rsp_if rsp_bus ();

  text_console_cursor_scroll dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_bus),
    .rsp      (rsp_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  int         cursor_at [NCON];
  int         start_at [NCON];
  int         active_con;
  logic [7:0] color_shadow;

  cmd_word_t  pending_cmds [$];
  rsp_word_t  expected_words [$];

  int send_idle_pct;
  int recv_idle_pct;
  int gap_left;
  int stall_left;
  int cycle_count;
  int mismatches;
  int words_checked;
  int cells_written;
  int deepest_start;
  int region_end_hits;
  int color_settings;

  cmd_word_t nxt;
  rsp_word_t want;
  rsp_word_t got;

  function automatic rsp_word_t apply_command(logic [1:0] act, logic [1:0] con,
                                              logic [7:0] ch);
    rsp_word_t w;
    int base;
    int lim;
    int off;
    w    = '0;
    base = int'(con) * REGION;
    lim  = base + REGION;
    case (act)
      ACT_PUT: begin
        off = cursor_at[con] - base;
        if (ch == CH_NEWLINE) begin
          if (REGION > LINE && off < REGION - LINE)
            cursor_at[con] = base + LINE * (off / LINE + 1);
        end else if (ch == CH_BACKSPACE) begin
          if (cursor_at[con] > base) begin
            cursor_at[con] = cursor_at[con] - 1;
            w.mem_write = 1'b1;
            w.mem_cell  = 14'(cursor_at[con]);
            w.mem_char  = CH_SPACE;
            w.mem_attr  = color_shadow;
          end
        end else if (cursor_at[con] + 1 < lim) begin
          w.mem_write = 1'b1;
          w.mem_cell  = 14'(cursor_at[con]);
          w.mem_char  = ch;
          w.mem_attr  = color_shadow;
          cursor_at[con] = cursor_at[con] + 1;
        end
        while (cursor_at[con] >= start_at[con] + SCREEN && start_at[con] + SCREEN < lim)
          start_at[con] = start_at[con] + LINE;
      end
      ACT_SCROLL_UP: begin
        if (start_at[con] > base) start_at[con] = start_at[con] - LINE;
      end
      ACT_SCROLL_DOWN: begin
        if (start_at[con] + SCREEN < lim) start_at[con] = start_at[con] + LINE;
      end
      default: begin
        active_con = int'(con);
      end
    endcase
    w.cursor_out     = 14'(cursor_at[con]);
    w.start_out      = 14'(start_at[con]);
    w.active_console = 2'(active_con);
    return w;
  endfunction

  task automatic check_field(string fname, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_val, act_val);
      mismatches++;
    end
  endtask

  task automatic queue_cmd(logic [1:0] act, logic [1:0] con, logic [7:0] ch);
    cmd_word_t c;
    c.action  = act;
    c.console = con;
    c.code    = ch;
    pending_cmds.push_back(c);
  endtask

  function automatic logic [7:0] any_code();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_random(int count);
    int focus;
    int r;
    int run;
    int n;
    int k;
    logic [1:0] act;
    logic [7:0] ch;
    logic [1:0] con;
    focus = $urandom_range(0, NCON - 1);
    n = 0;
    while (n < count) begin
      r   = $urandom_range(0, 99);
      con = 2'(focus);
      act = ACT_PUT;
      ch  = any_code();
      run = 1;
      if (r < 35) begin
        ch  = CH_NEWLINE;
        run = $urandom_range(1, 6);
      end else if (r < 60) begin
        run = $urandom_range(1, 8);
      end else if (r < 62) begin
        run = $urandom_range(40, 120);
      end else if (r < 70) begin
        ch  = CH_BACKSPACE;
        run = $urandom_range(1, 4);
      end else if (r < 71) begin
        ch  = CH_BACKSPACE;
        run = $urandom_range(30, 90);
      end else if (r < 76) begin
        act = ACT_SCROLL_UP;
        run = $urandom_range(1, 3);
      end else if (r < 78) begin
        act = ACT_SCROLL_UP;
        run = $urandom_range(10, 30);
      end else if (r < 83) begin
        act = ACT_SCROLL_DOWN;
        run = $urandom_range(1, 3);
      end else if (r < 85) begin
        act = ACT_SCROLL_DOWN;
        run = $urandom_range(10, 30);
      end else if (r < 91) begin
        act = ACT_SELECT;
        con = 2'($urandom_range(0, NCON - 1));
        if ($urandom_range(0, 1) == 1) focus = int'(con);
      end else if (r < 96) begin
        con = 2'($urandom_range(0, NCON - 1));
      end else begin
        focus = $urandom_range(0, NCON - 1);
        run = 0;
      end
      for (k = 0; k < run && n < count; k++) begin
        if (act != ACT_PUT || (ch != CH_NEWLINE && ch != CH_BACKSPACE))
          queue_cmd(act, con, (act == ACT_PUT) ? any_code() : ch);
        else
          queue_cmd(act, con, ch);
        ch = (act == ACT_PUT) ? ch : any_code();
        n++;
      end
    end
  endtask

  task automatic wait_drain();
    while (pending_cmds.size() != 0 || cmd_bus.valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_color(logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    color_shadow = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    color_settings++;
  endtask

  task automatic run_phase(logic [7:0] color, int count, int send_pct, int recv_pct);
    wait_drain();
    write_color(color);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    queue_random(count);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      cmd_bus.valid <= 1'b0;
      gap_left      <= 0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready)
        expected_words.push_back(apply_command(cmd_bus.action, cmd_bus.console_index,
                                               cmd_bus.char_code));
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (gap_left > 0) begin
          gap_left      <= gap_left - 1;
          cmd_bus.valid <= 1'b0;
        end else if (pending_cmds.size() == 0) begin
          cmd_bus.valid <= 1'b0;
        end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
          gap_left      <= $urandom_range(0, 13);
          cmd_bus.valid <= 1'b0;
        end else begin
          nxt = pending_cmds.pop_front();
          cmd_bus.valid         <= 1'b1;
          cmd_bus.action        <= nxt.action;
          cmd_bus.console_index <= nxt.console;
          cmd_bus.char_code     <= nxt.code;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (stall_left > 0) begin
        stall_left    <= stall_left - 1;
        rsp_bus.ready <= 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        stall_left    <= $urandom_range(0, 13);
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        got.mem_write      = rsp_bus.mem_write;
        got.mem_cell       = rsp_bus.mem_cell;
        got.mem_char       = rsp_bus.mem_char;
        got.mem_attr       = rsp_bus.mem_attr;
        got.cursor_out     = rsp_bus.cursor_out;
        got.start_out      = rsp_bus.start_out;
        got.active_console = rsp_bus.active_console;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %p", $time, got);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("mem_write", want.mem_write, got.mem_write);
          check_field("mem_cell", want.mem_cell, got.mem_cell);
          check_field("mem_char", want.mem_char, got.mem_char);
          check_field("mem_attr", want.mem_attr, got.mem_attr);
          check_field("cursor_out", want.cursor_out, got.cursor_out);
          check_field("start_out", want.start_out, got.start_out);
          check_field("active_console", want.active_console, got.active_console);
          words_checked++;
          if (want.mem_write) cells_written++;
          if (int'(want.start_out) % REGION > deepest_start)
            deepest_start = int'(want.start_out) % REGION;
          if (int'(want.cursor_out) % REGION == REGION - 1) region_end_hits++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("tb_text_console_cursor_scroll failed");
      $finish;
    end
  end

  initial begin
    int i;
    cmd_bus.valid         = 1'b0;
    cmd_bus.action        = ACT_PUT;
    cmd_bus.console_index = 2'd0;
    cmd_bus.char_code     = 8'd0;
    rsp_bus.ready         = 1'b0;
    cycle_count     = 0;
    gap_left        = 0;
    stall_left      = 0;
    mismatches      = 0;
    words_checked   = 0;
    cells_written   = 0;
    deepest_start   = 0;
    region_end_hits = 0;
    color_settings  = 1;
    send_idle_pct   = 20;
    recv_idle_pct   = 20;
    for (i = 0; i < NCON; i++) begin
      cursor_at[i] = i * REGION;
      start_at[i]  = i * REGION;
    end
    active_con   = 0;
    color_shadow = COLOR_RESET;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    queue_cmd(ACT_PUT, 2'd0, 8'h41);
    queue_cmd(ACT_PUT, 2'd0, 8'hFF);
    queue_cmd(ACT_PUT, 2'd0, 8'h00);
    queue_cmd(ACT_PUT, 2'd0, CH_BACKSPACE);
    queue_cmd(ACT_PUT, 2'd0, CH_NEWLINE);
    queue_cmd(ACT_PUT, 2'd0, CH_BACKSPACE);
    queue_cmd(ACT_PUT, 2'd1, CH_BACKSPACE);
    queue_cmd(ACT_PUT, 2'd1, CH_NEWLINE);
    queue_cmd(ACT_SCROLL_UP, 2'd2, 8'hFF);
    queue_cmd(ACT_SCROLL_DOWN, 2'd2, 8'h00);
    queue_cmd(ACT_SCROLL_DOWN, 2'd2, 8'h5A);
    queue_cmd(ACT_SCROLL_UP, 2'd2, 8'hA5);
    queue_cmd(ACT_SELECT, 2'd1, 8'h00);
    queue_cmd(ACT_PUT, 2'd3, 8'h7F);
    queue_cmd(ACT_PUT, 2'd3, 8'h80);
    queue_cmd(ACT_SELECT, 2'd3, 8'hFF);
    queue_cmd(ACT_SELECT, 2'd2, 8'h0F);
    queue_cmd(ACT_SELECT, 2'd0, 8'hF0);
    queue_cmd(ACT_PUT, 2'd2, 8'h55);
    queue_cmd(ACT_PUT, 2'd2, 8'hAA);
    queue_cmd(ACT_PUT, 2'd3, CH_NEWLINE);
    queue_cmd(ACT_SCROLL_UP, 2'd3, 8'h00);

    run_phase(8'h00, 400, 15, 15);
    run_phase(8'hFF, 400, 4, 30);
    run_phase(8'($urandom_range(0, 255)), 400, 30, 0);
    run_phase(8'($urandom_range(0, 255)), 330, 0, 0);
    wait_drain();

    $display("checked %0d result words over %0d color settings, %0d cell writes",
             words_checked, color_settings, cells_written);
    $display("deepest display start offset %0d, cursor at last region cell %0d times",
             deepest_start, region_end_hits);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("tb_text_console_cursor_scroll passed");
    end else begin
      $display("tb_text_console_cursor_scroll failed");
    end
    $finish;
  end

endmodule
